>>> sv/hull_point_halfspace_query_defines.svh
// assertion macros for the hull point half-space query block
// needs signals named clock and reset in the module that uses them
`ifndef HULL_POINT_HALFSPACE_QUERY_DEFINES_SVH
`define HULL_POINT_HALFSPACE_QUERY_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define HPQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define HPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/hpq_pkg.sv
// shared constants, codes and types of the hull point half-space query block
// no dependencies
`timescale 1ns / 1ps

package hpq_pkg;

   // table size and fixed-point format
   localparam int MAX_FACETS    = 64;
   localparam int FRAC_BITS     = 16;
   localparam int ADDR_W        = $clog2(MAX_FACETS);
   localparam int CNT_W         = $clog2(MAX_FACETS + 1);

   // field widths
   localparam int FUNC_W        = 1;
   localparam int FACET_INDEX_W = 6;
   localparam int FACET_COUNT_W = 7;
   localparam int EPSILON_W     = 31;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 31;
   localparam int NORMAL_W      = 18;
   localparam int COORD_W       = 32;
   localparam int DIST_W        = 32;

   // datapath widths
   localparam int DIFF_W        = COORD_W + 1;
   localparam int PROD_W        = NORMAL_W + DIFF_W;
   localparam int ACC_W         = PROD_W + 2;

   // widths that hold an index or count next to the table size
   localparam int IDX_EXT_W = ((ADDR_W > FACET_INDEX_W) ? ADDR_W : FACET_INDEX_W) + 1;
   localparam int LIM_W     = ((CNT_W > FACET_COUNT_W) ? CNT_W : FACET_COUNT_W) + 1;

   // saturation bounds of a distance
   localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7fffffff;
   localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh80000000;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FACET_COUNT = 1'b0,
      CSR_EPSILON     = 1'b1
   } csr_index_type;

   // item function codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD  = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   // vector component handled by the shared unit
   typedef enum logic [1:0] {
      COMP_X = 2'd0,
      COMP_Y = 2'd1,
      COMP_Z = 2'd2
   } comp_type;

   // one facet table entry
   typedef struct packed {
      logic signed [NORMAL_W-1:0] normal_z;
      logic signed [NORMAL_W-1:0] normal_y;
      logic signed [NORMAL_W-1:0] normal_x;
      logic signed [COORD_W-1:0]  vertex_z;
      logic signed [COORD_W-1:0]  vertex_y;
      logic signed [COORD_W-1:0]  vertex_x;
   } facet_entry_type;

   // sequencer to shared unit
   typedef struct packed {
      logic     issue;
      comp_type comp;
      logic     first;
      logic     last;
   } mac_ctrl_type;

   // shared unit to sequencer
   typedef struct packed {
      logic busy;
      logic dist_valid;
   } mac_status_type;

endpackage

>>> sv/hpq_if.sv
// valid/ready channels of the hull point half-space query block
// depends on hpq_pkg
`timescale 1ns / 1ps

// request channel: facet loads and point queries
interface hpq_req_if;
   logic                                      valid;
   logic                                      ready;
   logic [hpq_pkg::FUNC_W-1:0]                func;
   logic [hpq_pkg::FACET_INDEX_W-1:0]         facet_index;
   logic signed [hpq_pkg::NORMAL_W-1:0]       normal_x;
   logic signed [hpq_pkg::NORMAL_W-1:0]       normal_y;
   logic signed [hpq_pkg::NORMAL_W-1:0]       normal_z;
   logic signed [hpq_pkg::COORD_W-1:0]        vertex_x;
   logic signed [hpq_pkg::COORD_W-1:0]        vertex_y;
   logic signed [hpq_pkg::COORD_W-1:0]        vertex_z;
   logic signed [hpq_pkg::COORD_W-1:0]        query_x;
   logic signed [hpq_pkg::COORD_W-1:0]        query_y;
   logic signed [hpq_pkg::COORD_W-1:0]        query_z;

   modport source (
      output valid, func, facet_index, normal_x, normal_y, normal_z,
             vertex_x, vertex_y, vertex_z, query_x, query_y, query_z,
      input  ready
   );
   modport sink (
      input  valid, func, facet_index, normal_x, normal_y, normal_z,
             vertex_x, vertex_y, vertex_z, query_x, query_y, query_z,
      output ready
   );
endinterface

// response channel: one item per query
interface hpq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                inside_res;
   logic signed [hpq_pkg::DIST_W-1:0]   max_distance;
   logic                                no_facets;

   modport source (output valid, inside_res, max_distance, no_facets, input ready);
   modport sink (input valid, inside_res, max_distance, no_facets, output ready);
endinterface

>>> sv/hpq_facet_mem.sv
// facet table: one write port, one registered read port
// depends on hpq_pkg
`timescale 1ns / 1ps

module hpq_facet_mem (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [hpq_pkg::ADDR_W-1:0]      wr_addr,
   input  hpq_pkg::facet_entry_type        wr_data,
   input  logic                            rd_en,
   input  logic [hpq_pkg::ADDR_W-1:0]      rd_addr,
   output hpq_pkg::facet_entry_type        rd_data_ff
);

   hpq_pkg::facet_entry_type mem_ff [hpq_pkg::MAX_FACETS];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

>>> sv/hpq_mac.sv
// shared plane distance unit: subtract, multiply, accumulate, then floor shift and saturate
// one vector component per issue; depends on hpq_pkg
`timescale 1ns / 1ps

module hpq_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  hpq_pkg::mac_ctrl_type                ctrl,
   input  hpq_pkg::facet_entry_type             entry,
   input  logic signed [hpq_pkg::COORD_W-1:0]   query_x,
   input  logic signed [hpq_pkg::COORD_W-1:0]   query_y,
   input  logic signed [hpq_pkg::COORD_W-1:0]   query_z,
   output logic signed [hpq_pkg::DIST_W-1:0]    dist_ff,
   output hpq_pkg::mac_status_type              status
);

   logic signed [hpq_pkg::COORD_W-1:0]  query_sel;
   logic signed [hpq_pkg::COORD_W-1:0]  vertex_sel;
   logic signed [hpq_pkg::NORMAL_W-1:0] norm_in;
   logic signed [hpq_pkg::NORMAL_W-1:0] norm_ff;
   logic signed [hpq_pkg::DIFF_W-1:0]   diff_in;
   logic signed [hpq_pkg::DIFF_W-1:0]   diff_ff;
   logic                                d_valid_ff;
   logic                                d_first_ff;
   logic                                d_last_ff;
   logic signed [hpq_pkg::PROD_W-1:0]   prod_in;
   logic signed [hpq_pkg::PROD_W-1:0]   prod_ff;
   logic                                p_valid_ff;
   logic                                p_first_ff;
   logic                                p_last_ff;
   logic signed [hpq_pkg::ACC_W-1:0]    acc_in;
   logic signed [hpq_pkg::ACC_W-1:0]    acc_ff;
   logic                                a_done_ff;
   logic signed [hpq_pkg::ACC_W-1:0]    shifted;
   logic signed [hpq_pkg::DIST_W-1:0]   sat_in;
   logic                                dist_valid_ff;

   // component select
   always_comb begin
      case (ctrl.comp)
         hpq_pkg::COMP_X: begin
            query_sel  = query_x;
            vertex_sel = entry.vertex_x;
            norm_in    = entry.normal_x;
         end
         hpq_pkg::COMP_Y: begin
            query_sel  = query_y;
            vertex_sel = entry.vertex_y;
            norm_in    = entry.normal_y;
         end
         default: begin
            query_sel  = query_z;
            vertex_sel = entry.vertex_z;
            norm_in    = entry.normal_z;
         end
      endcase
      diff_in = hpq_pkg::DIFF_W'(query_sel) - hpq_pkg::DIFF_W'(vertex_sel);
   end

   // signed product at full width
   assign prod_in = norm_ff * diff_ff;

   // accumulate, the first component restarts the sum
   assign acc_in = p_first_ff ? hpq_pkg::ACC_W'(prod_ff)
                              : acc_ff + hpq_pkg::ACC_W'(prod_ff);

   // floor shift and clamp to the distance range
   always_comb begin
      shifted = acc_ff >>> hpq_pkg::FRAC_BITS;
      if (shifted > hpq_pkg::ACC_W'(hpq_pkg::DIST_MAX)) begin
         sat_in = hpq_pkg::DIST_MAX;
      end else if (shifted < hpq_pkg::ACC_W'(hpq_pkg::DIST_MIN)) begin
         sat_in = hpq_pkg::DIST_MIN;
      end else begin
         sat_in = shifted[hpq_pkg::DIST_W-1:0];
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff    <= 1'b0;
         p_valid_ff    <= 1'b0;
         a_done_ff     <= 1'b0;
         dist_valid_ff <= 1'b0;
      end else begin
         d_valid_ff    <= ctrl.issue;
         p_valid_ff    <= d_valid_ff;
         a_done_ff     <= p_valid_ff & p_last_ff;
         dist_valid_ff <= a_done_ff;
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (ctrl.issue) begin
         diff_ff    <= diff_in;
         norm_ff    <= norm_in;
         d_first_ff <= ctrl.first;
         d_last_ff  <= ctrl.last;
      end
      if (d_valid_ff) begin
         prod_ff    <= prod_in;
         p_first_ff <= d_first_ff;
         p_last_ff  <= d_last_ff;
      end
      if (p_valid_ff) begin
         acc_ff <= acc_in;
      end
      if (a_done_ff) begin
         dist_ff <= sat_in;
      end
   end

   assign status.busy       = d_valid_ff | p_valid_ff | a_done_ff | dist_valid_ff;
   assign status.dist_valid = dist_valid_ff;

endmodule

>>> sv/hull_point_halfspace_query.sv
// a query with no facets goes straight to the done state, else it walks the n facets in turn;
// the shared multiplier takes one vector component per cycle
// load items are written at accept; after a query the next item is accepted once the result is registered
// a finished result waits in the output register while the next item is taken
// synchronous active-high reset clears control and configuration registers; facet table is not cleared
`timescale 1ns / 1ps
`include "hull_point_halfspace_query_defines.svh"

module hull_point_halfspace_query (
   input  logic                                clock,
   input  logic                                reset,
   hpq_req_if.sink                             req_chan,
   hpq_rsp_if.source                           rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [hpq_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [hpq_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_FETCH = 7'b0000010,
      ST_X     = 7'b0000100,
      ST_Y     = 7'b0001000,
      ST_Z     = 7'b0010000,
      ST_DRAIN = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type                               state_ff, state_in;
   logic [hpq_pkg::FACET_COUNT_W-1:0]       facet_count_ff;
   logic [hpq_pkg::EPSILON_W-1:0]           epsilon_ff;
   logic signed [hpq_pkg::COORD_W-1:0]      query_x_ff, query_y_ff, query_z_ff;
   logic [hpq_pkg::CNT_W-1:0]               walk_ff, walk_in, walk_next;
   logic [hpq_pkg::CNT_W-1:0]               limit_ff, limit_in;
   logic [hpq_pkg::LIM_W-1:0]               count_ext;
   logic [hpq_pkg::IDX_EXT_W-1:0]           index_ext;
   logic signed [hpq_pkg::DIST_W-1:0]       best_ff;
   logic                                    rsp_valid_ff;
   logic                                    rsp_inside_ff;
   logic signed [hpq_pkg::DIST_W-1:0]       rsp_max_ff;
   logic                                    rsp_none_ff;
   logic                                    accept;
   logic                                    query_acc;
   logic                                    load_acc;
   logic                                    walk_last;
   logic                                    rsp_load;
   logic                                    none_now;
   logic                                    inside_now;
   logic                                    mem_wr_en;
   logic                                    mem_rd_en;
   logic [hpq_pkg::ADDR_W-1:0]              mem_rd_addr;
   hpq_pkg::facet_entry_type                wr_entry;
   hpq_pkg::facet_entry_type                rd_entry;
   hpq_pkg::mac_ctrl_type                   mac_ctrl;
   hpq_pkg::mac_status_type                 mac_status;
   logic signed [hpq_pkg::DIST_W-1:0]       mac_dist;

   // input handshake and item decode
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept    = req_chan.valid & req_chan.ready;
   assign query_acc = accept & (hpq_pkg::func_type'(req_chan.func) == hpq_pkg::FUNC_QUERY);
   assign load_acc  = accept & (hpq_pkg::func_type'(req_chan.func) == hpq_pkg::FUNC_LOAD);

   // walk limit: facet count clamped to the table size
   assign count_ext = hpq_pkg::LIM_W'(facet_count_ff);
   assign limit_in  = (count_ext > hpq_pkg::LIM_W'(hpq_pkg::MAX_FACETS))
                      ? hpq_pkg::CNT_W'(hpq_pkg::MAX_FACETS)
                      : count_ext[hpq_pkg::CNT_W-1:0];

   // facet writes, indexes past the table are dropped
   assign index_ext = hpq_pkg::IDX_EXT_W'(req_chan.facet_index);
   assign mem_wr_en = load_acc & (index_ext < hpq_pkg::IDX_EXT_W'(hpq_pkg::MAX_FACETS));
   assign wr_entry.normal_x = req_chan.normal_x;
   assign wr_entry.normal_y = req_chan.normal_y;
   assign wr_entry.normal_z = req_chan.normal_z;
   assign wr_entry.vertex_x = req_chan.vertex_x;
   assign wr_entry.vertex_y = req_chan.vertex_y;
   assign wr_entry.vertex_z = req_chan.vertex_z;

   // facet walk, next entry is read during the last component of the current one
   assign walk_next   = walk_ff + 1'b1;
   assign walk_last   = (walk_next == limit_ff);
   assign mem_rd_en   = (state_ff == ST_FETCH) | ((state_ff == ST_Z) & ~walk_last);
   assign mem_rd_addr = (state_ff == ST_Z) ? walk_next[hpq_pkg::ADDR_W-1:0]
                                           : walk_ff[hpq_pkg::ADDR_W-1:0];

   hpq_facet_mem u_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (index_ext[hpq_pkg::ADDR_W-1:0]),
      .wr_data    (wr_entry),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (rd_entry)
   );

   // shared unit control
   always_comb begin
      mac_ctrl.issue = (state_ff == ST_X) | (state_ff == ST_Y) | (state_ff == ST_Z);
      mac_ctrl.first = (state_ff == ST_X);
      mac_ctrl.last  = (state_ff == ST_Z);
      case (state_ff)
         ST_X:    mac_ctrl.comp = hpq_pkg::COMP_X;
         ST_Y:    mac_ctrl.comp = hpq_pkg::COMP_Y;
         default: mac_ctrl.comp = hpq_pkg::COMP_Z;
      endcase
   end

   hpq_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .entry   (rd_entry),
      .query_x (query_x_ff),
      .query_y (query_y_ff),
      .query_z (query_z_ff),
      .dist_ff (mac_dist),
      .status  (mac_status)
   );

   // result formation
   assign none_now   = (limit_ff == '0);
   assign inside_now = none_now |
                       ($signed({best_ff[hpq_pkg::DIST_W-1], best_ff}) <=
                        $signed({2'b00, epsilon_ff}));
   assign rsp_load   = (state_ff == ST_DONE) & (~rsp_valid_ff | rsp_chan.ready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      walk_in  = walk_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_acc) begin
               walk_in  = '0;
               state_in = (limit_in == '0) ? ST_DONE : ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_X;
         ST_X:     state_in = ST_Y;
         ST_Y:     state_in = ST_Z;
         ST_Z: begin
            walk_in  = walk_next;
            state_in = walk_last ? ST_DRAIN : ST_X;
         end
         ST_DRAIN: begin
            if (!mac_status.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         walk_ff      <= '0;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         walk_ff  <= walk_in;
         if (query_acc) begin
            limit_ff <= limit_in;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         facet_count_ff <= '0;
         epsilon_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (hpq_pkg::csr_index_type'(csr_index))
            hpq_pkg::CSR_FACET_COUNT: facet_count_ff <= csr_wr_data[hpq_pkg::FACET_COUNT_W-1:0];
            hpq_pkg::CSR_EPSILON:     epsilon_ff     <= csr_wr_data[hpq_pkg::EPSILON_W-1:0];
            default: ;
         endcase
      end
   end

   // query point, running maximum and result register
   always_ff @(posedge clock) begin
      if (query_acc) begin
         query_x_ff <= req_chan.query_x;
         query_y_ff <= req_chan.query_y;
         query_z_ff <= req_chan.query_z;
         best_ff    <= hpq_pkg::DIST_MIN;
      end else if (mac_status.dist_valid && (mac_dist > best_ff)) begin
         best_ff <= mac_dist;
      end
      if (rsp_load) begin
         rsp_inside_ff <= inside_now;
         rsp_max_ff    <= none_now ? hpq_pkg::DIST_MAX : best_ff;
         rsp_none_ff   <= none_now;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.inside_res   = rsp_inside_ff;
   assign rsp_chan.max_distance = rsp_max_ff;
   assign rsp_chan.no_facets    = rsp_none_ff;

   // checks
   `HPQ_ASSERT_NEXT(a_query_walks, query_acc && (limit_in != '0), state_ff == ST_FETCH, "query with facets did not start a walk")
   `HPQ_ASSERT_SAME(a_walk_in_range, state_ff == ST_FETCH, walk_ff < limit_ff, "walk index beyond facet limit")
   `HPQ_ASSERT_SAME(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE, "result raised outside done state")
   `HPQ_ASSERT_SAME(a_empty_result, rsp_valid_ff && rsp_none_ff, rsp_inside_ff && (rsp_max_ff == hpq_pkg::DIST_MAX), "empty hull result malformed")
   `HPQ_ASSERT_SAME(a_idle_unit_quiet, state_ff == ST_IDLE, !mac_status.busy, "distance unit busy while idle")

endmodule

>>> test/hull_query_checker.sv
// checker for the hull point half-space query block: watches both channels and the csr port
// keeps its own facet table and predicts each query result; depends on hpq_pkg and hpq_if
`timescale 1ns / 1ps

module hull_query_checker import hpq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   hpq_req_if                     req_mon,
   hpq_rsp_if                     rsp_mon,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   output int unsigned            mismatches,
   output int unsigned            verdicts_waiting
);

   // predicted outcome of one query
   typedef struct {
      logic                     in_hull;
      logic signed [DIST_W-1:0] distance;
      logic                     walked_none;
   } halfspace_verdict_type;

   facet_entry_type          facet_table [MAX_FACETS];
   logic [FACET_COUNT_W-1:0] walk_count;
   logic [EPSILON_W-1:0]     tolerance;
   halfspace_verdict_type    verdicts_due [$];

   initial begin
      mismatches       = 0;
      verdicts_waiting = 0;
   end

   // largest plane distance of a point over the walked facets
   function automatic halfspace_verdict_type judge_point(input logic signed [COORD_W-1:0] px,
                                                         input logic signed [COORD_W-1:0] py,
                                                         input logic signed [COORD_W-1:0] pz);
      halfspace_verdict_type v;
      int                    n;
      longint                acc;
      longint                plane;
      longint                best;
      n = (walk_count > MAX_FACETS) ? MAX_FACETS : int'(walk_count);
      if (n == 0) begin
         v.in_hull     = 1'b1;
         v.distance    = DIST_MAX;
         v.walked_none = 1'b1;
         return v;
      end
      best = longint'(DIST_MIN);
      for (int i = 0; i < n; i++) begin
         acc = longint'(facet_table[i].normal_x) * (longint'(px) - longint'(facet_table[i].vertex_x))
             + longint'(facet_table[i].normal_y) * (longint'(py) - longint'(facet_table[i].vertex_y))
             + longint'(facet_table[i].normal_z) * (longint'(pz) - longint'(facet_table[i].vertex_z));
         // arithmetic shift rounds toward minus infinity
         plane = acc >>> FRAC_BITS;
         if (plane > longint'(DIST_MAX)) plane = longint'(DIST_MAX);
         if (plane < longint'(DIST_MIN)) plane = longint'(DIST_MIN);
         if (plane > best) best = plane;
      end
      v.in_hull     = (best <= longint'(tolerance)) ? 1'b1 : 1'b0;
      v.distance    = DIST_W'(best);
      v.walked_none = 1'b0;
      return v;
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // one pass per rising edge: csr writes, accepted items, accepted results
   always @(posedge clock) begin
      halfspace_verdict_type want;
      if (reset) begin
         walk_count = '0;
         tolerance  = '0;
         verdicts_due.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_FACET_COUNT) walk_count = csr_wr_data[FACET_COUNT_W-1:0];
            else if (csr_index == CSR_EPSILON) tolerance = csr_wr_data[EPSILON_W-1:0];
         end

         // accepted request item
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            if (req_mon.func == FUNC_LOAD) begin
               if (req_mon.facet_index < MAX_FACETS) begin
                  facet_table[req_mon.facet_index].normal_x = req_mon.normal_x;
                  facet_table[req_mon.facet_index].normal_y = req_mon.normal_y;
                  facet_table[req_mon.facet_index].normal_z = req_mon.normal_z;
                  facet_table[req_mon.facet_index].vertex_x = req_mon.vertex_x;
                  facet_table[req_mon.facet_index].vertex_y = req_mon.vertex_y;
                  facet_table[req_mon.facet_index].vertex_z = req_mon.vertex_z;
               end
            end else begin
               verdicts_due.insert(verdicts_due.size(),
                                   judge_point(req_mon.query_x, req_mon.query_y,
                                               req_mon.query_z));
            end
         end

         // accepted result item against the oldest prediction
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (verdicts_due.size() == 0) begin
               flag_mismatch($sformatf("result with no query waiting, distance %0d",
                                       rsp_mon.max_distance));
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_mon.inside_res !== want.in_hull)
                  flag_mismatch($sformatf("inside_res got %b, wanted %b",
                                          rsp_mon.inside_res, want.in_hull));
               if (rsp_mon.max_distance !== want.distance)
                  flag_mismatch($sformatf("max_distance got %0d, wanted %0d",
                                          rsp_mon.max_distance, want.distance));
               if (rsp_mon.no_facets !== want.walked_none)
                  flag_mismatch($sformatf("no_facets got %b, wanted %b",
                                          rsp_mon.no_facets, want.walked_none));
            end
         end
      end
      verdicts_waiting = verdicts_due.size();
   end

endmodule

>>> test/tb_top.sv
// top of the hull point half-space query testbench: clock, reset, stimulus and verdict
// depends on hpq_pkg, hpq_if, the block itself and hull_query_checker
`timescale 1ns / 1ps

module tb_top;
   import hpq_pkg::*;

   localparam int unsigned RUN_LIMIT   = 800000;
   localparam int          ITEM_TARGET = 850;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fffffff;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;
   localparam logic [EPSILON_W-1:0]      EPS_MAX   = 31'h7fffffff;

   // one request item as offered to the block
   typedef struct {
      func_type                    func;
      logic [FACET_INDEX_W-1:0]    index;
      logic signed [NORMAL_W-1:0]  nx, ny, nz;
      logic signed [COORD_W-1:0]   vx, vy, vz;
      logic signed [COORD_W-1:0]   qx, qy, qz;
   } hull_item_type;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;
   int unsigned            mismatches;
   int unsigned            verdicts_waiting;
   int unsigned            cycle_count = 0;
   int                     items_sent  = 0;
   bit                     send_eager  = 1'b0;

   hpq_req_if req_chan ();
   hpq_rsp_if rsp_chan ();

   hull_point_halfspace_query u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   hull_query_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .mismatches       (mismatches),
      .verdicts_waiting (verdicts_waiting)
   );

   // 2 ns clock
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // random field values, weighted towards extremes and small magnitudes
   function automatic logic signed [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 7))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2, 3:    return $urandom;
         default: return int'($urandom_range(0, 32'h200000)) - 32'h100000;
      endcase
   endfunction

   function automatic logic signed [NORMAL_W-1:0] rand_normal();
      case ($urandom_range(0, 7))
         0:       return 18'sd65536;
         1:       return -18'sd65536;
         2:       return '0;
         default: return NORMAL_W'(int'($urandom_range(0, 131072)) - 65536);
      endcase
   endfunction

   function automatic hull_item_type make_load(input logic [FACET_INDEX_W-1:0] idx,
                                               input logic signed [NORMAL_W-1:0] nx,
                                               input logic signed [NORMAL_W-1:0] ny,
                                               input logic signed [NORMAL_W-1:0] nz,
                                               input logic signed [COORD_W-1:0] vx,
                                               input logic signed [COORD_W-1:0] vy,
                                               input logic signed [COORD_W-1:0] vz);
      hull_item_type it;
      it.func  = FUNC_LOAD;
      it.index = idx;
      it.nx = nx; it.ny = ny; it.nz = nz;
      it.vx = vx; it.vy = vy; it.vz = vz;
      // query fields carry noise on a load
      it.qx = rand_coord(); it.qy = rand_coord(); it.qz = rand_coord();
      return it;
   endfunction

   function automatic hull_item_type make_query(input logic signed [COORD_W-1:0] qx,
                                                input logic signed [COORD_W-1:0] qy,
                                                input logic signed [COORD_W-1:0] qz);
      hull_item_type it;
      it.func  = FUNC_QUERY;
      it.index = FACET_INDEX_W'($urandom_range(0, 63));
      it.nx = rand_normal(); it.ny = rand_normal(); it.nz = rand_normal();
      it.vx = rand_coord();  it.vy = rand_coord();  it.vz = rand_coord();
      it.qx = qx; it.qy = qy; it.qz = qz;
      return it;
   endfunction

   function automatic hull_item_type random_load();
      return make_load(FACET_INDEX_W'($urandom_range(0, 63)), rand_normal(), rand_normal(),
                       rand_normal(), rand_coord(), rand_coord(), rand_coord());
   endfunction

   // mostly short walks, now and then the whole table or beyond it
   function automatic logic [FACET_COUNT_W-1:0] pick_count();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 7'd1;
         2:       return 7'd64;
         3:       return FACET_COUNT_W'($urandom_range(65, 127));
         4:       return 7'd127;
         default: return FACET_COUNT_W'($urandom_range(2, 8));
      endcase
   endfunction

   function automatic logic [EPSILON_W-1:0] pick_epsilon();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return EPS_MAX;
         2:       return EPSILON_W'($urandom);
         default: return EPSILON_W'($urandom_range(0, 32'h100000));
      endcase
   endfunction

   // offer one item after a random gap and hold it until accepted
   task automatic offer_item(input hull_item_type it);
      int gap;
      gap = send_eager ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.func        <= it.func;
      req_chan.facet_index <= it.index;
      req_chan.normal_x    <= it.nx;
      req_chan.normal_y    <= it.ny;
      req_chan.normal_z    <= it.nz;
      req_chan.vertex_x    <= it.vx;
      req_chan.vertex_y    <= it.vy;
      req_chan.vertex_z    <= it.vz;
      req_chan.query_x     <= it.qx;
      req_chan.query_y     <= it.qy;
      req_chan.query_z     <= it.qz;
      req_chan.valid       <= 1'b1;
      do @(posedge clock); while (!(req_chan.valid === 1'b1 && req_chan.ready === 1'b1));
      @(negedge clock);
      items_sent++;
   endtask

   // stop offering and wait until every query has answered
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (verdicts_waiting != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   task automatic retune(input logic [FACET_COUNT_W-1:0] cnt, input logic [EPSILON_W-1:0] eps);
      settle();
      write_csr(CSR_FACET_COUNT, CSR_DATA_W'(cnt));
      write_csr(CSR_EPSILON, CSR_DATA_W'(eps));
   endtask

   // random loads and queries over the whole table
   task automatic run_mix_phase(input int phase_no);
      logic [FACET_COUNT_W-1:0] cnt;
      logic [EPSILON_W-1:0]     eps;
      int                       n;
      case (phase_no)
         0:       begin cnt = 7'd64;  eps = '0;      end
         1:       begin cnt = 7'd127; eps = EPS_MAX; end
         2:       begin cnt = '0;     eps = '0;      end
         3:       begin cnt = 7'd65;  eps = 31'd1;   end
         default: begin cnt = pick_count(); eps = pick_epsilon(); end
      endcase
      retune(cnt, eps);
      n = $urandom_range(20, 50);
      repeat (n) begin
         if ($urandom_range(0, 99) < 35) offer_item(random_load());
         else offer_item(make_query(rand_coord(), rand_coord(), rand_coord()));
      end
   endtask

   // axis-aligned box in entries 0 to 5, then points in and around it
   task automatic run_box_phase();
      int cx, cy, cz, h, reach, n;
      cx = int'($urandom_range(0, 32'h2000000)) - 32'h1000000;
      cy = int'($urandom_range(0, 32'h2000000)) - 32'h1000000;
      cz = int'($urandom_range(0, 32'h2000000)) - 32'h1000000;
      h  = int'($urandom_range(1, 32'h400000));
      reach = h + h / 4 + 1;
      retune(7'd6, EPSILON_W'($urandom_range(0, 32'h10000)));
      offer_item(make_load(6'd0, 18'sd65536, '0, '0, cx + h, cy + rand_coord() / 512, cz));
      offer_item(make_load(6'd1, -18'sd65536, '0, '0, cx - h, cy, cz + rand_coord() / 512));
      offer_item(make_load(6'd2, '0, 18'sd65536, '0, cx, cy + h, cz));
      offer_item(make_load(6'd3, '0, -18'sd65536, '0, cx + rand_coord() / 512, cy - h, cz));
      offer_item(make_load(6'd4, '0, '0, 18'sd65536, cx, cy, cz + h));
      offer_item(make_load(6'd5, '0, '0, -18'sd65536, cx, cy, cz - h));
      n = $urandom_range(25, 45);
      repeat (n) begin
         case ($urandom_range(0, 9))
            // loads beyond the walked entries leave the box as it is
            0: offer_item(make_load(FACET_INDEX_W'($urandom_range(6, 63)), rand_normal(),
                                    rand_normal(), rand_normal(), rand_coord(), rand_coord(),
                                    rand_coord()));
            1: offer_item(make_query(rand_coord(), rand_coord(), rand_coord()));
            // point on the +x face
            2: offer_item(make_query(cx + h, cy, cz));
            default: offer_item(make_query(
                        cx + int'($urandom_range(0, 2 * reach)) - reach,
                        cy + int'($urandom_range(0, 2 * reach)) - reach,
                        cz + int'($urandom_range(0, 2 * reach)) - reach));
         endcase
      end
   endtask

   // result side: random back-pressure, two long hold-offs, eager stretches
   initial begin : rsp_side
      int          gap;
      int unsigned taken;
      bit          eager;
      taken = 0;
      eager = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         if (taken == 30 || taken == 300) begin
            rsp_chan.ready <= 1'b0;
            repeat (400) @(negedge clock);
         end
         gap = eager ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1));
         taken++;
         if (taken % 64 == 0) eager = ($urandom_range(0, 2) == 0);
         @(negedge clock);
      end
   end

   // stimulus and verdict
   initial begin : req_side
      int phase_no;
      req_chan.valid       = 1'b0;
      req_chan.func        = FUNC_LOAD;
      req_chan.facet_index = '0;
      req_chan.normal_x    = '0;
      req_chan.normal_y    = '0;
      req_chan.normal_z    = '0;
      req_chan.vertex_x    = '0;
      req_chan.vertex_y    = '0;
      req_chan.vertex_z    = '0;
      req_chan.query_x     = '0;
      req_chan.query_y     = '0;
      req_chan.query_z     = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // no facets straight after reset
      offer_item(make_query(COORD_MAX, COORD_MIN, '0));
      offer_item(make_query('0, '0, '0));

      // entries 0 to 5: axis normal, saturating high and low, floor rounding, mixed signs
      offer_item(make_load(6'd0, 18'sd65536, '0, '0, '0, '0, '0));
      offer_item(make_load(6'd1, 18'sd65536, 18'sd65536, 18'sd65536,
                           COORD_MIN, COORD_MIN, COORD_MIN));
      offer_item(make_load(6'd2, 18'sd65536, 18'sd65536, 18'sd65536,
                           COORD_MAX, COORD_MAX, COORD_MAX));
      offer_item(make_load(6'd3, -18'sd1, -18'sd1, -18'sd1, '0, '0, '0));
      offer_item(make_load(6'd4, -18'sd65536, 18'sd65536, -18'sd65536,
                           COORD_MAX, COORD_MIN, '0));
      offer_item(make_load(6'd5, 18'sd1, '0, -18'sd1, 32'sd1, -32'sd1, '0));

      // single facet, zero tolerance: on the plane, just outside, just inside
      retune(7'd1, '0);
      offer_item(make_query('0, '0, '0));
      offer_item(make_query(32'sd1, '0, '0));
      offer_item(make_query(-32'sd1, '0, '0));

      retune(7'd4, 31'd1);
      offer_item(make_query(COORD_MAX, COORD_MAX, COORD_MAX));
      offer_item(make_query(COORD_MIN, COORD_MIN, COORD_MIN));
      offer_item(make_query(32'sd1, 32'sd1, 32'sd1));

      retune(7'd6, EPS_MAX);
      offer_item(make_query(COORD_MAX, COORD_MIN, COORD_MAX));
      offer_item(make_query('0, '0, '0));
      offer_item(make_query(-32'sd1, 32'sd1, -32'sd1));

      // fill the whole table so that any facet count is legal from here on
      for (int i = 0; i < MAX_FACETS; i++)
         offer_item(make_load(FACET_INDEX_W'(i), rand_normal(), rand_normal(), rand_normal(),
                              rand_coord(), rand_coord(), rand_coord()));

      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         send_eager = ($urandom_range(0, 3) == 0);
         if (phase_no >= 4 && $urandom_range(0, 2) == 0) run_box_phase();
         else run_mix_phase(phase_no);
         phase_no++;
      end

      settle();
      repeat (250) @(negedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> hull_point_halfspace_query.f
+incdir+sv
sv/hpq_pkg.sv
sv/hpq_if.sv
sv/hpq_facet_mem.sv
sv/hpq_mac.sv
sv/hull_point_halfspace_query.sv
test/hull_query_checker.sv
test/tb_top.sv
